@@ rtl/periodic_alarm_timer_table_unit_assert.svh @@
// Assertion macros for the checker module.
`ifndef PERIODIC_ALARM_TIMER_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_ALARM_TIMER_TABLE_UNIT_ASSERT_SVH

// An implication that must hold at every rising clock edge out of reset.
`define PATT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define PATT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/patt_pkg.sv @@
package patt_pkg;

  typedef enum logic [1:0] {
    MODE_REG   = 2'd0,
    MODE_UNREG = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_REG_ACK   = 3'd0,
    KIND_UNREG_ACK = 3'd1,
    KIND_CLEAR_ACK = 3'd2,
    KIND_FIRED     = 3'd3,
    KIND_IDLE_TICK = 3'd4
  } kind_t;

  localparam int MAX_FIRE = 16;
  localparam logic [31:0] T_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] interval_sec;
    logic        repeat_req;
    logic [15:0] alarm_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic        ok;
    logic        last;
    logic [31:0] next_delay;
    logic [15:0] next_alarm_id;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? T_MAX : s[31:0];
  endfunction

endpackage

@@ rtl/patt_if.sv @@
interface patt_cmd_if import patt_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface patt_res_if import patt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/periodic_alarm_timer_table_unit.sv @@
// Alarm timer table with a seconds counter. Commands enter a two-word queue;
// the engine then visits one slot per cycle for register, unregister, clear
// and tick, and waits whenever the result side stalls. Every result word reports
// the delay to, and id of, the earliest pending alarm.
module periodic_alarm_timer_table_unit import patt_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  patt_cmd_if.sink   in_cmd,
  patt_res_if.source out_res
);
  patt_cmd_if q_if ();

  patt_front u_front (
    .clk(clk), .rst_n(rst_n), .cmd_in(in_cmd), .cmd_out(q_if.source)
  );

  patt_engine #(.NUM_SLOTS(NUM_SLOTS), .ID_BITS(ID_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd(q_if.sink), .res(out_res)
  );
endmodule

@@ rtl/patt_front.sv @@
// Accepts command words and holds them in a two-entry queue for the engine.
module patt_front import patt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  patt_cmd_if.sink   cmd_in,
  patt_cmd_if.source cmd_out
);
  cmd_t     q_r [2];
  logic [1:0] cnt_r;
  logic     rd_r;
  logic     wr_r;

  logic push, pop;
  assign cmd_in.ready  = (cnt_r != 2'd2);
  assign push          = cmd_in.valid && cmd_in.ready;
  assign cmd_out.valid = (cnt_r != 2'd0);
  assign cmd_out.data  = q_r[rd_r];
  assign pop           = cmd_out.valid && cmd_out.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        q_r[wr_r] <= cmd_in.data;
        wr_r <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ rtl/patt_engine.sv @@
// Executes commands against the slot table, one slot visited per cycle.
module patt_engine import patt_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  patt_cmd_if.sink   cmd,
  patt_res_if.source res
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int FW = $clog2(MAX_FIRE + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_ACT, S_SCAN, S_EMIT
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;
  logic [NUM_SLOTS-1:0] valid_r, fired_r;
  logic [ID_BITS-1:0]   id_r [NUM_SLOTS];
  logic [31:0]          intv_r [NUM_SLOTS];
  logic                 rep_r [NUM_SLOTS];
  logic [31:0]          due_r [NUM_SLOTS];
  logic [31:0]          now_r;
  logic [ID_BITS-1:0]   idc_r;
  logic [CW-1:0]        idx_r;
  logic                 hit_r;
  logic [SW-1:0]        hit_slot_r;
  logic [31:0]          b_due_r;
  logic [ID_BITS-1:0]   b_id_r;
  logic                 due_pass_r;   // scanning for due alarms, else for earliest pending
  logic                 more_r;       // another unfired alarm is still due
  logic [FW-1:0]        nfire_r;
  res_t                 out_r;
  logic                 out_v_r;
  kind_t                kind_r;
  logic [15:0]          rid_r;
  logic                 ok_r;
  logic                 last_r;

  logic [SW-1:0] si;
  logic          cand, better;
  assign si = idx_r[SW-1:0];
  assign cand = valid_r[si] && !(due_pass_r && (fired_r[si] || due_r[si] > now_r));
  assign better = !hit_r || (due_r[si] < b_due_r) ||
                  ((due_r[si] == b_due_r) && (id_r[si] < b_id_r));

  logic [ID_BITS-1:0] new_id, nxt_idc;
  assign new_id  = (idc_r == '0) ? {{(ID_BITS-1){1'b0}}, 1'b1} : idc_r;
  assign nxt_idc = ((new_id + 1'b1) == '0) ? {{(ID_BITS-1){1'b0}}, 1'b1} : new_id + 1'b1;

  assign cmd.ready = (state_r == S_IDLE);
  assign res.valid = out_v_r;
  assign res.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      fired_r <= '0;
      now_r   <= '0;
      idc_r   <= {{(ID_BITS-1){1'b0}}, 1'b1};
      out_v_r <= 1'b0;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      due_pass_r <= 1'b0;
      more_r  <= 1'b0;
      nfire_r <= '0;
    end else begin
      if (res.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r <= cmd.data;
            idx_r <= '0;
            hit_r <= 1'b0;
            fired_r <= '0;
            nfire_r <= '0;
            due_pass_r <= 1'b0;
            if (cmd.data.mode == MODE_TICK) begin
              now_r <= sat_add(now_r, 32'd1);
              due_pass_r <= 1'b1;
              state_r <= S_SCAN;
            end else if (cmd.data.mode == MODE_CLEAR) begin
              valid_r <= '0;
              kind_r <= KIND_CLEAR_ACK; rid_r <= '0; ok_r <= 1'b0; last_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_FIND;
            end
          end
        end
        S_FIND: begin
          // Lowest free slot for register, lowest matching slot for unregister.
          if (!hit_r) begin
            if (cmd_r.mode == MODE_REG ? !valid_r[si]
                : (valid_r[si] && (16'(id_r[si]) == cmd_r.alarm_id) &&
                   (ID_BITS <= 16 || (id_r[si] >> 16) == '0))) begin
              hit_r <= 1'b1;
              hit_slot_r <= si;
            end
          end
          if (idx_r == CW'(NUM_SLOTS - 1)) state_r <= S_ACT;
          else idx_r <= idx_r + 1'b1;
        end
        S_ACT: begin
          last_r <= 1'b1;
          if (cmd_r.mode == MODE_REG) begin
            kind_r <= KIND_REG_ACK;
            if (hit_r) begin
              valid_r[hit_slot_r] <= 1'b1;
              id_r[hit_slot_r]    <= new_id;
              intv_r[hit_slot_r]  <= cmd_r.interval_sec;
              rep_r[hit_slot_r]   <= cmd_r.repeat_req;
              due_r[hit_slot_r]   <= sat_add(now_r, cmd_r.interval_sec);
              idc_r <= nxt_idc;
              rid_r <= 16'(new_id); ok_r <= 1'b1;
            end else begin
              rid_r <= '0; ok_r <= 1'b0;
            end
          end else begin
            kind_r <= KIND_UNREG_ACK;
            if (hit_r) begin
              valid_r[hit_slot_r] <= 1'b0;
              rid_r <= cmd_r.alarm_id; ok_r <= 1'b1;
            end else begin
              rid_r <= '0; ok_r <= 1'b0;
            end
          end
          idx_r <= '0; hit_r <= 1'b0; due_pass_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cand && better) begin
            hit_r <= 1'b1; hit_slot_r <= si;
            b_due_r <= due_r[si]; b_id_r <= id_r[si];
          end
          // The pending pass also tells whether the tick has more to fire.
          if (!due_pass_r && valid_r[si] && !fired_r[si] && due_r[si] <= now_r)
            more_r <= 1'b1;
          if (idx_r == CW'(NUM_SLOTS - 1)) state_r <= S_EMIT;
          else idx_r <= idx_r + 1'b1;
        end
        S_EMIT: begin
          if (due_pass_r) begin
            // Take the earliest due alarm, or report a tick with nothing due.
            idx_r <= '0; hit_r <= 1'b0; due_pass_r <= 1'b0; more_r <= 1'b0;
            if (hit_r) begin
              fired_r[hit_slot_r] <= 1'b1;
              nfire_r <= nfire_r + 1'b1;
              kind_r <= KIND_FIRED; rid_r <= 16'(b_id_r); ok_r <= 1'b0;
              if (rep_r[hit_slot_r] && intv_r[hit_slot_r] != '0)
                due_r[hit_slot_r] <= sat_add(now_r, intv_r[hit_slot_r]);
              else
                valid_r[hit_slot_r] <= 1'b0;
              last_r <= 1'b0;
            end else begin
              kind_r <= KIND_IDLE_TICK; rid_r <= '0; ok_r <= 1'b0; last_r <= 1'b1;
            end
            state_r <= S_SCAN;
          end else if (!out_v_r || res.ready) begin
            out_v_r <= 1'b1;
            out_r.kind <= kind_r;
            out_r.result_id <= rid_r;
            out_r.ok <= ok_r;
            out_r.last <= last_r ||
                          (kind_r == KIND_FIRED && (nfire_r == FW'(MAX_FIRE) || !more_r));
            out_r.next_delay <= (hit_r && b_due_r > now_r) ? b_due_r - now_r : '0;
            out_r.next_alarm_id <= hit_r ? 16'(b_id_r) : '0;
            if (kind_r == KIND_FIRED && nfire_r != FW'(MAX_FIRE) && more_r && !last_r) begin
              idx_r <= '0; hit_r <= 1'b0; due_pass_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/patt_checker.sv @@
`include "periodic_alarm_timer_table_unit_assert.svh"

module patt_checker import patt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input res_t out_data
);
  `PATT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped while stalled")
  `PATT_ASSERT_IMP(a_kind_range, clk, rst_n, out_valid, out_data.kind <= KIND_IDLE_TICK, "bad result kind")
  `PATT_ASSERT_IMP(a_ack_last, clk, rst_n, out_valid && out_data.kind != KIND_FIRED, out_data.last, "ack word without last")
  `PATT_ASSERT_IMP(a_empty_delay, clk, rst_n, out_valid && out_data.next_alarm_id == '0, out_data.next_delay == '0, "delay with empty table")
endmodule

bind periodic_alarm_timer_table_unit patt_checker u_patt_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_res.valid),
  .out_ready(out_res.ready), .out_data(out_res.data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import patt_pkg::*;

  // Predicts the result words of the alarm table and checks them in order.
  class alarm_table_scoreboard;
    bit          slot_on[16];
    bit          slot_rpt[16];
    logic [31:0] slot_tag[16];
    logic [31:0] slot_ivl[16];
    logic [31:0] slot_due[16];
    logic [31:0] now_sec;
    logic [31:0] id_next;
    res_t        expected_q[$];
    int          errors;
    int          checked;
    int          fired_seen;

    function new();
      now_sec = 0;
      id_next = 1;
      errors = 0;
      checked = 0;
      fired_seen = 0;
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Earliest valid slot by due time, ties to the smaller id; -1 if none.
    function int earliest_slot(bit skip[16], bit due_only);
      int best;
      best = -1;
      for (int i = 0; i < 16; i++) begin
        if (!slot_on[i] || skip[i]) continue;
        if (due_only && slot_due[i] > now_sec) continue;
        if (best < 0 || slot_due[i] < slot_due[best] ||
            (slot_due[i] == slot_due[best] && slot_tag[i] < slot_tag[best]))
          best = i;
      end
      return best;
    endfunction

    function void add_word(kind_t k, logic [15:0] rid, bit ok);
      res_t r;
      bit none[16];
      int n;
      foreach (none[i]) none[i] = 0;
      n = earliest_slot(none, 0);
      r.kind = k;
      r.result_id = rid;
      r.ok = ok;
      r.last = 0;
      if (n < 0) begin
        r.next_delay = 0;
        r.next_alarm_id = 0;
      end else begin
        r.next_delay = slot_due[n] > now_sec ? slot_due[n] - now_sec : 32'd0;
        r.next_alarm_id = slot_tag[n][15:0];
      end
      expected_q.push_back(r);
    endfunction

    function void note_cmd(cmd_t c);
      int s;
      int cnt;
      bit fired[16];
      logic [31:0] tag;
      s = -1;
      cnt = 0;
      case (c.mode)
        MODE_REG: begin
          for (int i = 0; i < 16; i++)
            if (!slot_on[i]) begin s = i; break; end
          if (s < 0) begin
            add_word(KIND_REG_ACK, 0, 0);
          end else begin
            tag = id_next[15:0] == 0 ? 32'd1 : {16'd0, id_next[15:0]};
            slot_on[s] = 1;
            slot_tag[s] = tag;
            slot_ivl[s] = c.interval_sec;
            slot_rpt[s] = c.repeat_req;
            slot_due[s] = add_sat(now_sec, c.interval_sec);
            id_next = (tag + 1) & 32'hFFFF;
            if (id_next == 0) id_next = 1;
            add_word(KIND_REG_ACK, tag[15:0], 1);
          end
        end
        MODE_UNREG: begin
          for (int i = 0; i < 16; i++)
            if (slot_on[i] && slot_tag[i] == {16'd0, c.alarm_id}) begin s = i; break; end
          if (s >= 0) begin
            slot_on[s] = 0;
            add_word(KIND_UNREG_ACK, c.alarm_id, 1);
          end else begin
            add_word(KIND_UNREG_ACK, 0, 0);
          end
        end
        MODE_CLEAR: begin
          foreach (slot_on[i]) slot_on[i] = 0;
          add_word(KIND_CLEAR_ACK, 0, 0);
        end
        default: begin
          foreach (fired[i]) fired[i] = 0;
          now_sec = add_sat(now_sec, 1);
          while (cnt < MAX_FIRE) begin
            s = earliest_slot(fired, 1);
            if (s < 0) break;
            fired[s] = 1;
            tag = slot_tag[s];
            if (slot_rpt[s] && slot_ivl[s] != 0)
              slot_due[s] = add_sat(now_sec, slot_ivl[s]);
            else
              slot_on[s] = 0;
            add_word(KIND_FIRED, tag[15:0], 0);
            cnt++;
          end
          if (cnt == 0) add_word(KIND_IDLE_TICK, 0, 0);
        end
      endcase
      expected_q[expected_q.size() - 1].last = 1;
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: result word %0d: %s is %0h, expected %0h",
               $time, checked, what, got, want);
    endfunction

    function void check_res(res_t r);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: %p", $time, r);
        return;
      end
      e = expected_q.pop_front();
      if (r.kind != e.kind) report("kind", r.kind, e.kind);
      if (r.result_id != e.result_id) report("result_id", r.result_id, e.result_id);
      if (r.ok != e.ok) report("ok", r.ok, e.ok);
      if (r.last != e.last) report("last", r.last, e.last);
      if (r.next_delay != e.next_delay) report("next_delay", r.next_delay, e.next_delay);
      if (r.next_alarm_id != e.next_alarm_id)
        report("next_alarm_id", r.next_alarm_id, e.next_alarm_id);
      if (e.kind == KIND_FIRED) fired_seen++;
      checked++;
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   gaps_on;
  int   stall_pct;
  int   hold_cnt;
  int   idle_cycles;
  int   sent;

  alarm_table_scoreboard sb;

  patt_cmd_if cmd_if ();
  patt_res_if res_if ();

  periodic_alarm_timer_table_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_if.sink),
    .out_res(res_if.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid stays high across back-to-back words so it gets one assignment per step.
  task send_cmd(cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_cmd(c);
    sent++;
  endtask

  task send_fields(mode_t m, logic [31:0] ivl, bit rpt, logic [15:0] aid);
    cmd_t c;
    c.mode = m;
    c.interval_sec = ivl;
    c.repeat_req = rpt;
    c.alarm_id = aid;
    send_cmd(c);
  endtask

  task drain();
    cmd_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task send_random();
    cmd_t c;
    int r;
    int s;
    r = $urandom_range(0, 99);
    c.interval_sec = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) c.interval_sec = $urandom;
    c.repeat_req = $urandom_range(0, 1);
    c.alarm_id = $urandom;
    if (r < 40) begin
      c.mode = MODE_REG;
    end else if (r < 60) begin
      c.mode = MODE_UNREG;
      s = $urandom_range(0, 15);
      // Mostly aim at a live alarm so removals actually happen.
      if ($urandom_range(0, 3) != 0 && sb.slot_on[s]) c.alarm_id = sb.slot_tag[s][15:0];
      else if ($urandom_range(0, 5) == 0) c.alarm_id = 0;
    end else if (r < 64) begin
      c.mode = MODE_CLEAR;
    end else begin
      c.mode = MODE_TICK;
    end
    send_cmd(c);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (res_if.valid && res_if.ready) sb.check_res(res_if.data);
      if (hold_cnt > 0) begin
        res_if.ready <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < 2) begin
        res_if.ready <= 1'b0;
        hold_cnt <= $urandom_range(10, 50);
      end else begin
        res_if.ready <= stall_pct == 0 || $urandom_range(0, 99) >= stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    gaps_on = 0;
    stall_pct = 0;
    sent = 0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: interval extremes, zero-interval repeat, unknown ids,
    // a full table and a tick that fires sixteen alarms at once.
    send_fields(MODE_REG, 32'd0, 0, 16'd0);
    send_fields(MODE_REG, 32'd0, 1, 16'hFFFF);
    send_fields(MODE_REG, 32'hFFFF_FFFF, 1, 16'd0);
    send_fields(MODE_REG, 32'd2, 1, 16'd0);
    send_fields(MODE_UNREG, 32'hFFFF_FFFF, 1, 16'd0);
    send_fields(MODE_UNREG, 32'd0, 0, 16'hFFFF);
    send_fields(MODE_TICK, 32'd0, 0, 16'd0);
    send_fields(MODE_TICK, 32'hFFFF_FFFF, 1, 16'hFFFF);
    send_fields(MODE_TICK, 32'd0, 0, 16'd0);
    send_fields(MODE_UNREG, 32'd0, 0, 16'd3);
    send_fields(MODE_CLEAR, 32'd0, 0, 16'd0);
    for (int i = 0; i < 17; i++) send_fields(MODE_REG, 32'd1, i % 2, 16'd0);
    send_fields(MODE_TICK, 32'd0, 0, 16'd0);
    send_fields(MODE_TICK, 32'd0, 0, 16'd0);
    drain();

    // Random phases with changing gap and stall behavior.
    for (int p = 0; p < 5; p++) begin
      gaps_on = p % 3 != 0;
      stall_pct = (p % 2) ? $urandom_range(10, 60) : 0;
      for (int i = 0; i < 40; i++) send_random();
      if (p == 3) begin
        drain();
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
    end
    drain();

    // Full-speed words with regular clears, then a stalled tail.
    gaps_on = 0;
    stall_pct = 0;
    for (int i = 0; i < 40; i++) begin
      if (i % 10 == 9) send_fields(MODE_CLEAR, 32'd0, 0, 16'd0);
      else send_random();
    end
    gaps_on = 1;
    stall_pct = 20;
    for (int i = 0; i < 30; i++) send_random();
    drain();
    repeat (200) @(posedge clk);

    $display("%0d command words sent, %0d result words checked, %0d alarm fires",
             sent, sb.checked, sb.fired_seen);
    $display("covered full table, sixteen-fire tick, zero-interval repeat, stalls");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.errors, sb.expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
